### sv/pgn_pkg.sv
// ----------------------------------------------------------------------------
// pgn_pkg
// Shared types and constants of the gradient norm and angle block.
// ----------------------------------------------------------------------------
`default_nettype none
package pgn_pkg;

  localparam int MaxWidth   = 1024;
  localparam int ColBits    = 10;
  localparam int RowBits    = 12;
  localparam int PixBits    = 16;
  localparam int GradBits   = 18;
  localparam int NormBits   = 17;
  localparam int AngleBits  = 16;
  localparam int CordSteps  = 31;
  localparam int SqrtSteps  = 18;
  localparam int CordBits   = 42;
  localparam int ZBits      = 34;
  localparam int ScaleShift = 36 - PixBits;

  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic signed [ZBits-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [16:0] AngleLimit = 17'sd25736;

  // one window handed from front to back
  typedef struct packed {
    logic [ColBits-1:0]  pos_x;
    logic [RowBits-1:0]  pos_y;
    logic [GradBits-1:0] gx;
    logic [GradBits-1:0] gy;
    logic                frame_last;
    logic                clear_max;
  } win_t;

  // arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/pixel_gradient_norm_angle.sv
// For each pixel the front reads the line buffer, then forms the window;
// a window then passes the queue to the back, where the 31-step CORDIC runs.
// The back holds one window at a time in the shared root/CORDIC unit and takes
// the next from the queue only when idle; the front takes a new pixel only when
// done with the last, and pixels that form no window never wait on the queue.
// Reset: synchronous active-high rst clears counters, queues and registers to
// 640x480, threshold 1365; the line buffer is not cleared.
// ----------------------------------------------------------------------------
// pixel_gradient_norm_angle
// 2x2 gradient norm and angle over a raster pixel stream.
// ----------------------------------------------------------------------------
`default_nettype none
module pixel_gradient_norm_angle (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [15:0]  pixel_value,
  output logic              empty,
  input  wire logic         pop,
  output logic [9:0]        pos_x,
  output logic [11:0]       pos_y,
  output logic [16:0]       grad_norm,
  output logic signed [15:0] grad_angle,
  output logic              angle_defined,
  output logic [16:0]       frame_max_norm,
  output logic              frame_last,
  input  wire logic         wr_en,
  input  wire logic [1:0]   wr_index,
  input  wire logic [16:0]  wr_data
);

  logic [10:0] image_width;
  logic [11:0] image_height;
  logic [16:0] grad_threshold;
  logic [10:0] width_eff;
  logic [11:0] height_eff;
  logic          win_push;
  pgn_pkg::win_t win_in;
  pgn_pkg::win_t win_out;
  logic          win_full;
  logic          win_empty;
  logic          win_rd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 11'd640;
      image_height   <= 12'd480;
      grad_threshold <= 17'd1365;
    end else if (wr_en) begin
      unique case (wr_index)
        pgn_pkg::REG_WIDTH:     image_width    <= wr_data[10:0];
        pgn_pkg::REG_HEIGHT:    image_height   <= wr_data[11:0];
        pgn_pkg::REG_THRESHOLD: grad_threshold <= wr_data;
        default: ;
      endcase
    end
  end

  // clamp geometry
  always_comb begin
    if (image_width < 11'd2) begin
      width_eff = 11'd2;
    end else if (image_width > 11'(pgn_pkg::MaxWidth)) begin
      width_eff = 11'(pgn_pkg::MaxWidth);
    end else begin
      width_eff = image_width;
    end
    height_eff = (image_height < 12'd2) ? 12'd2 : image_height;
  end

  pgn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pixel_value (pixel_value),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .win_push    (win_push),
    .win_data    (win_in),
    .win_full    (win_full)
  );

  pgn_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (win_push),
    .wr_data (win_in),
    .q_full  (win_full),
    .rd      (win_rd),
    .rd_data (win_out),
    .q_empty (win_empty)
  );

  pgn_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (win_empty),
    .q_data         (win_out),
    .q_rd           (win_rd),
    .threshold      (grad_threshold),
    .empty          (empty),
    .pop            (pop),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .grad_norm      (grad_norm),
    .grad_angle     (grad_angle),
    .angle_defined  (angle_defined),
    .frame_max_norm (frame_max_norm),
    .frame_last     (frame_last)
  );

endmodule
`default_nettype wire

### sv/pgn_front.sv
// ----------------------------------------------------------------------------
// pgn_front
// Accepts pixels, keeps the line buffer and forms 2x2 window gradients.
// ----------------------------------------------------------------------------
`default_nettype none
module pgn_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [pgn_pkg::PixBits-1:0]  pixel_value,
  input  wire logic [10:0]                  width_eff,
  input  wire logic [11:0]                  height_eff,
  output logic                              win_push,
  output pgn_pkg::win_t                     win_data,
  input  wire logic                         win_full
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t state;
  logic [pgn_pkg::ColBits-1:0] column_count;
  logic [pgn_pkg::RowBits-1:0] row_count;
  logic [pgn_pkg::ColBits-1:0] col_q;
  logic [pgn_pkg::RowBits-1:0] row_q;
  logic [pgn_pkg::PixBits-1:0] d_q;
  logic [pgn_pkg::PixBits-1:0] rd_data;
  logic [pgn_pkg::PixBits-1:0] prev_cur;
  logic [pgn_pkg::PixBits-1:0] prev_prev;
  logic                        clear_pend;
  logic [pgn_pkg::PixBits-1:0] row_buffer [pgn_pkg::MaxWidth];

  logic                        col_wrap;
  logic [pgn_pkg::RowBits:0]   row_inc;
  logic [pgn_pkg::ColBits-1:0] col0;
  logic [pgn_pkg::RowBits-1:0] row0;
  logic                        accept;
  logic                        is_win;
  logic                        done;
  logic signed [16:0]          com1;
  logic signed [16:0]          com2;
  logic [10:0]                 col_next;
  logic [pgn_pkg::RowBits:0]   row_next;

  // wrap counters left beyond the geometry
  always_comb begin
    col_wrap = {1'b0, column_count} >= width_eff;
    row_inc  = {1'b0, row_count} + {{pgn_pkg::RowBits{1'b0}}, col_wrap};
    col0     = col_wrap ? '0 : column_count;
    row0     = (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[pgn_pkg::RowBits-1:0];
  end

  assign full   = (state != S_IDLE);
  assign accept = push && (state == S_IDLE);

  // window gradients
  always_comb begin
    is_win = (col_q != '0) && (row_q != '0);
    com1   = $signed({1'b0, d_q}) - $signed({1'b0, prev_prev});
    com2   = $signed({1'b0, rd_data}) - $signed({1'b0, prev_cur});
    win_data.pos_x      = col_q - 1'b1;
    win_data.pos_y      = row_q - 1'b1;
    win_data.gx         = $unsigned(18'(com1) + 18'(com2));
    win_data.gy         = $unsigned(18'(com1) - 18'(com2));
    win_data.frame_last = ({1'b0, col_q} == width_eff - 11'd1) &&
                          (row_q == height_eff - 12'd1);
    win_data.clear_max  = clear_pend;
    done     = (state == S_READ) && !(is_win && win_full);
    win_push = (state == S_READ) && is_win && !win_full;
    col_next = {1'b0, col_q} + 11'd1;
    row_next = {1'b0, row_q} + 13'd1;
  end

  // line buffer
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= row_buffer[col0];
    end
    if (done) begin
      row_buffer[col_q] <= d_q;
    end
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= '0;
      row_count    <= '0;
      prev_cur     <= '0;
      prev_prev    <= '0;
      clear_pend   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            col_q <= col0;
            row_q <= row0;
            d_q   <= pixel_value;
            if (col0 == '0 && row0 == '0) begin
              clear_pend <= 1'b1;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          if (done) begin
            if (win_push) begin
              clear_pend <= 1'b0;
            end
            prev_prev <= rd_data;
            prev_cur  <= d_q;
            if (col_next >= width_eff) begin
              column_count <= '0;
              row_count    <= (row_next >= {1'b0, height_eff}) ? '0 :
                              row_next[pgn_pkg::RowBits-1:0];
            end else begin
              column_count <= col_next[pgn_pkg::ColBits-1:0];
              row_count    <= row_q;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/pgn_queue.sv
// ----------------------------------------------------------------------------
// pgn_queue
// Two-entry queue of windows between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module pgn_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  pgn_pkg::win_t      wr_data,
  output logic               q_full,
  input  wire logic          rd,
  output pgn_pkg::win_t      rd_data,
  output logic               q_empty
);

  pgn_pkg::win_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_data = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      slots[wptr] <= wr_data;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr && !q_full) begin
        wptr <= ~wptr;
      end
      if (rd && !q_empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'((wr && !q_full) ? 1 : 0) - 2'((rd && !q_empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

### sv/pgn_back.sv
// ----------------------------------------------------------------------------
// pgn_back
// Iterative square root and vectoring CORDIC, frame maximum, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module pgn_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_empty,
  input  pgn_pkg::win_t                       q_data,
  output logic                                q_rd,
  input  wire logic [pgn_pkg::NormBits-1:0]   threshold,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [pgn_pkg::ColBits-1:0]         pos_x,
  output logic [pgn_pkg::RowBits-1:0]         pos_y,
  output logic [pgn_pkg::NormBits-1:0]        grad_norm,
  output logic signed [pgn_pkg::AngleBits-1:0] grad_angle,
  output logic                                angle_defined,
  output logic [pgn_pkg::NormBits-1:0]        frame_max_norm,
  output logic                                frame_last
);

  typedef enum logic [1:0] {S_IDLE, S_SQ, S_RUN, S_DONE} state_t;

  state_t state;
  pgn_pkg::win_t win;
  logic [4:0]  cnt;
  logic [35:0] sum_v;
  logic [19:0] rem;
  logic [17:0] root;
  logic signed [pgn_pkg::CordBits-1:0] cx;
  logic signed [pgn_pkg::CordBits-1:0] cy;
  logic signed [pgn_pkg::ZBits-1:0]    cz;
  logic [pgn_pkg::NormBits-1:0] run_max;
  logic out_valid;

  logic signed [35:0] px;
  logic signed [35:0] py;
  logic signed [pgn_pkg::CordBits-1:0] x0;
  logic signed [pgn_pkg::CordBits-1:0] y0;
  logic [19:0] rem_t;
  logic [19:0] trial;
  logic signed [pgn_pkg::CordBits-1:0] xs;
  logic signed [pgn_pkg::CordBits-1:0] ys;
  logic signed [pgn_pkg::ZBits-1:0]    at;
  logic [pgn_pkg::NormBits-1:0] norm;
  logic defined;
  logic signed [pgn_pkg::ZBits-1:0] zr_full;
  logic signed [16:0] zr;
  logic signed [16:0] ang;
  logic out_free;

  assign empty    = !out_valid;
  assign q_rd     = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || pop;

  // squares and CORDIC start vector
  always_comb begin
    px = $signed(win.gx) * $signed(win.gx);
    py = $signed(win.gy) * $signed(win.gy);
    x0 = -(pgn_pkg::CordBits'($signed(win.gy)) <<< pgn_pkg::ScaleShift);
    y0 = pgn_pkg::CordBits'($signed(win.gx)) <<< pgn_pkg::ScaleShift;
  end

  // one root digit and one micro-rotation
  always_comb begin
    rem_t = {rem[17:0], sum_v[35:34]};
    trial = {root, 2'b01};
    xs    = cx >>> cnt;
    ys    = cy >>> cnt;
    at    = $signed({2'b00, pgn_pkg::atan_q30(cnt)});
  end

  // final rounding, clamp and threshold
  always_comb begin
    norm    = root[17:1];
    defined = norm > threshold;
    zr_full = (cz + 34'sd65536) >>> 17;
    zr      = zr_full[16:0];
    if (zr > pgn_pkg::AngleLimit) begin
      ang = pgn_pkg::AngleLimit;
    end else if (zr < -pgn_pkg::AngleLimit) begin
      ang = -pgn_pkg::AngleLimit;
    end else begin
      ang = zr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      run_max   <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            win   <= q_data;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (win.clear_max) begin
            run_max <= '0;
          end
          sum_v <= $unsigned(px) + $unsigned(py);
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          if (x0 < 0) begin
            if (y0 >= 0) begin
              cx <= y0;
              cy <= -x0;
              cz <= pgn_pkg::HalfPiQ30;
            end else begin
              cx <= -y0;
              cy <= x0;
              cz <= -pgn_pkg::HalfPiQ30;
            end
          end else begin
            cx <= x0;
            cy <= y0;
            cz <= '0;
          end
          state <= S_RUN;
        end
        S_RUN: begin
          if (cnt < 5'(pgn_pkg::SqrtSteps)) begin
            sum_v <= {sum_v[33:0], 2'b00};
            if (rem_t >= trial) begin
              rem  <= rem_t - trial;
              root <= {root[16:0], 1'b1};
            end else begin
              rem  <= rem_t;
              root <= {root[16:0], 1'b0};
            end
          end
          if (cy > 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(pgn_pkg::CordSteps - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            pos_x         <= win.pos_x;
            pos_y         <= win.pos_y;
            grad_norm     <= norm;
            grad_angle    <= defined ? ang[15:0] : '0;
            angle_defined <= defined;
            frame_last    <= win.frame_last;
            if (defined && norm > run_max) begin
              run_max        <= norm;
              frame_max_norm <= norm;
            end else begin
              frame_max_norm <= run_max;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
